// File: sv/rsa_pkg.sv
`default_nettype none

package rsa_pkg;

    localparam int DATA_W   = 32;
    localparam int OP_W     = 3;
    localparam int DEPTH_W  = 7;
    localparam int STATUS_W = 2;

    localparam int DEF_STACK_DEPTH = 64;
    localparam int DEF_VALUE_WIDTH = 32;

    // slave side: tdata = {denominator, numerator}, tuser = {is_ratio, operation}
    localparam int TDATA_IN_W = 2 * DATA_W;
    localparam int TUSER_IN_W = OP_W + 1;

    // master side fields, padded to whole bytes
    localparam int OUT_FIELDS_W = 2 * DATA_W + DEPTH_W + STATUS_W;
    localparam int TDATA_OUT_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    // request queue between front and back
    localparam int Q_AW    = 1;
    localparam int Q_DEPTH = 1 << Q_AW;

    typedef enum logic [OP_W-1:0] {
        OPC_PUSH = 3'd0,
        OPC_ADD  = 3'd1,
        OPC_SUB  = 3'd2,
        OPC_MUL  = 3'd3,
        OPC_DIV  = 3'd4,
        OPC_POP  = 3'd5
    } opcode_t;

    typedef enum logic [1:0] {
        KIND_PUSH  = 2'd0,
        KIND_ARITH = 2'd1,
        KIND_POP   = 2'd2,
        KIND_NOP   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ALU_ADD = 2'd0,
        ALU_SUB = 2'd1,
        ALU_MUL = 2'd2,
        ALU_DIV = 2'd3
    } alu_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_UNDERFLOW = 2'd1,
        STAT_OVERFLOW  = 2'd2
    } status_t;

    typedef struct packed {
        kind_t             kind;
        alu_t              alu;
        logic              is_ratio;
        logic [DATA_W-1:0] num;
        logic [DATA_W-1:0] den;
    } req_t;

endpackage

`default_nettype wire

// File: sv/rational_stack_alu_unit.sv
// Operand stack of typed values (integer, or unreduced ratio n/d) with push, add, sub,
// mul, div and pop; every request returns one result: the new top (the popped value for
// pop), the depth and a status (ok, underflow, overflow; the stack is left unchanged on
// error). Arithmetic wraps to VALUE_WIDTH bits, values are reported sign-extended to 32.
// A two-entry request queue decouples input from execution, and the result sits in an
// output register, so input is taken while a result waits. In the execution unit, push,
// pop and error cases go from the registered two-port read of the stack store straight
// to write-back; arithmetic puts three passes through the single shared VALUE_WIDTH-bit
// multiplier between the two. No clearing pass follows reset.
`default_nettype none

module rational_stack_alu_unit #(
    parameter int STACK_DEPTH = rsa_pkg::DEF_STACK_DEPTH,
    parameter int VALUE_WIDTH = rsa_pkg::DEF_VALUE_WIDTH
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [31:0] push_numerator, [63:32] push_denominator
    input  wire logic [rsa_pkg::TDATA_IN_W-1:0]  s_axis_tdata,
    // [2:0] operation, [3] push_is_ratio
    input  wire logic [rsa_pkg::TUSER_IN_W-1:0]  s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // [31:0] top_numerator, [63:32] top_denominator, [70:64] depth, [72:71] status
    output logic [rsa_pkg::TDATA_OUT_W-1:0]      m_axis_tdata,
    // [0] top_is_ratio
    output logic                                 m_axis_tuser
);
    import rsa_pkg::*;

    logic               req_valid;
    logic               req_ready;
    req_t               req;
    logic [DATA_W-1:0]  out_num;
    logic [DATA_W-1:0]  out_den;
    logic [DEPTH_W-1:0] out_depth;
    status_t            out_status;

    rsa_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .req_valid     (req_valid),
        .req_ready     (req_ready),
        .req           (req)
    );

    rsa_back #(
        .STACK_DEPTH (STACK_DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_ready    (req_ready),
        .req          (req),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .out_is_ratio (m_axis_tuser),
        .out_num      (out_num),
        .out_den      (out_den),
        .out_depth    (out_depth),
        .out_status   (out_status)
    );

    assign m_axis_tdata = TDATA_OUT_W'({out_status, out_depth, out_den, out_num});

endmodule

`default_nettype wire

// File: sv/rsa_front.sv
`default_nettype none

module rsa_front (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // [31:0] push_numerator, [63:32] push_denominator
    input  wire logic [rsa_pkg::TDATA_IN_W-1:0] s_axis_tdata,
    // [2:0] operation, [3] push_is_ratio
    input  wire logic [rsa_pkg::TUSER_IN_W-1:0] s_axis_tuser,
    output logic                                req_valid,
    input  wire logic                           req_ready,
    output rsa_pkg::req_t                       req
);
    import rsa_pkg::*;

    localparam logic [Q_AW:0] QFULL = (Q_AW + 1)'(Q_DEPTH);

    req_t            cls;
    req_t            q_reg [Q_DEPTH];
    logic [Q_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_AW:0]   count_reg, count_next;
    logic            push_fire;
    logic            pop_fire;

    // classify the incoming request
    always_comb
    begin
        cls.is_ratio = s_axis_tuser[OP_W];
        cls.num      = s_axis_tdata[DATA_W-1:0];
        cls.den      = s_axis_tuser[OP_W] ? s_axis_tdata[2*DATA_W-1:DATA_W] : '0;
        cls.kind     = KIND_NOP;
        cls.alu      = ALU_ADD;
        case (opcode_t'(s_axis_tuser[OP_W-1:0]))
            OPC_PUSH: cls.kind = KIND_PUSH;
            OPC_ADD:
            begin
                cls.kind = KIND_ARITH;
                cls.alu  = ALU_ADD;
            end
            OPC_SUB:
            begin
                cls.kind = KIND_ARITH;
                cls.alu  = ALU_SUB;
            end
            OPC_MUL:
            begin
                cls.kind = KIND_ARITH;
                cls.alu  = ALU_MUL;
            end
            OPC_DIV:
            begin
                cls.kind = KIND_ARITH;
                cls.alu  = ALU_DIV;
            end
            OPC_POP:  cls.kind = KIND_POP;
            default:  cls.kind = KIND_NOP;
        endcase
    end

    assign s_axis_tready = (count_reg != QFULL);
    assign req_valid     = (count_reg != '0);
    assign req           = q_reg[rd_ptr_reg];
    assign push_fire     = s_axis_tvalid && s_axis_tready;
    assign pop_fire      = req_valid && req_ready;

    always_comb
    begin
        wr_ptr_next = push_fire ? wr_ptr_reg + Q_AW'(1) : wr_ptr_reg;
        rd_ptr_next = pop_fire ? rd_ptr_reg + Q_AW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push_fire && !pop_fire)
        begin
            count_next = count_reg + (Q_AW + 1)'(1);
        end
        else if (!push_fire && pop_fire)
        begin
            count_next = count_reg - (Q_AW + 1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_fire)
        begin
            q_reg[wr_ptr_reg] <= cls;
        end
    end

endmodule

`default_nettype wire

// File: sv/rsa_back.sv
`default_nettype none

module rsa_back #(
    parameter int STACK_DEPTH = rsa_pkg::DEF_STACK_DEPTH,
    parameter int VALUE_WIDTH = rsa_pkg::DEF_VALUE_WIDTH
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         req_valid,
    output logic                              req_ready,
    input  wire rsa_pkg::req_t                req,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic                              out_is_ratio,
    output logic [rsa_pkg::DATA_W-1:0]        out_num,
    output logic [rsa_pkg::DATA_W-1:0]        out_den,
    output logic [rsa_pkg::DEPTH_W-1:0]       out_depth,
    output rsa_pkg::status_t                  out_status
);
    import rsa_pkg::*;

    localparam int VW = VALUE_WIDTH;
    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int EW = 1 + 2 * VW;
    localparam logic [CW-1:0] FULL = CW'(STACK_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_MUL  = 3'b010,
        S_DONE = 3'b100
    } state_t;

    state_t          state_reg, state_next;
    req_t            req_reg;
    logic [CW-1:0]   depth_reg;
    logic [1:0]      step_reg, step_next;
    logic [VW-1:0]   p0_reg, p1_reg, p2_reg;

    logic [EW-1:0]   mem [STACK_DEPTH];
    logic [EW-1:0]   rd_a_reg, rd_b_reg;
    logic [AW-1:0]   addr_a, addr_b;

    logic            req_fire;
    logic            out_load;
    logic            out_valid_reg;
    logic            out_is_ratio_reg;
    logic [DATA_W-1:0]  out_num_reg, out_den_reg;
    logic [DEPTH_W-1:0] out_depth_reg;
    status_t         out_status_reg;

    logic            a_rat, b_rat;
    logic [VW-1:0]   an, ad, bn, bd;
    logic [VW-1:0]   mul_x, mul_y, prod;

    logic            res_rat;
    logic [VW-1:0]   res_num, res_den;
    logic [VW-1:0]   push_num, push_den;

    logic            rep_valid, rep_rat;
    logic [VW-1:0]   rep_num, rep_den;
    status_t         rep_status;
    logic [CW-1:0]   depth_next;
    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    logic [EW-1:0]   wr_data;

    assign addr_b = AW'(depth_reg - CW'(1));
    assign addr_a = AW'(depth_reg - CW'(2));

    assign req_ready = (state_reg == S_IDLE);
    assign req_fire  = req_valid && req_ready;
    assign out_load  = (state_reg == S_DONE) && (!out_valid_reg || out_ready);

    // entry layout: {is_ratio, denominator, numerator}
    assign a_rat = rd_a_reg[EW-1];
    assign b_rat = rd_b_reg[EW-1];
    assign an    = rd_a_reg[VW-1:0];
    assign bn    = rd_b_reg[VW-1:0];
    assign ad    = a_rat ? rd_a_reg[2*VW-1:VW] : VW'(1);
    assign bd    = b_rat ? rd_b_reg[2*VW-1:VW] : VW'(1);

    // one shared multiplier: numerator terms first, denominator last
    always_comb
    begin
        case (step_reg)
            2'd0:
            begin
                mul_x = an;
                mul_y = (req_reg.alu == ALU_MUL) ? bn : bd;
            end
            2'd1:
            begin
                mul_x = bn;
                mul_y = ad;
            end
            default:
            begin
                mul_x = ad;
                mul_y = (req_reg.alu == ALU_DIV) ? bn : bd;
            end
        endcase
    end

    assign prod = mul_x * mul_y;

    always_comb
    begin
        res_rat = (req_reg.alu == ALU_DIV) || a_rat || b_rat;
        case (req_reg.alu)
            ALU_ADD: res_num = p0_reg + p1_reg;
            ALU_SUB: res_num = p0_reg - p1_reg;
            default: res_num = p0_reg;
        endcase
        res_den = res_rat ? p2_reg : '0;
    end

    assign push_num = req_reg.num[VW-1:0];
    assign push_den = req_reg.den[VW-1:0];

    // outcome of the request held in req_reg
    always_comb
    begin
        rep_valid  = (depth_reg != '0);
        rep_rat    = b_rat;
        rep_num    = bn;
        rep_den    = rd_b_reg[2*VW-1:VW];
        rep_status = STAT_OK;
        depth_next = depth_reg;
        wr_en      = 1'b0;
        wr_addr    = addr_a;
        wr_data    = {res_rat, res_den, res_num};
        case (req_reg.kind)
            KIND_PUSH:
            begin
                if (depth_reg == FULL)
                begin
                    rep_status = STAT_OVERFLOW;
                end
                else
                begin
                    wr_en      = 1'b1;
                    wr_addr    = AW'(depth_reg);
                    wr_data    = {req_reg.is_ratio, push_den, push_num};
                    rep_valid  = 1'b1;
                    rep_rat    = req_reg.is_ratio;
                    rep_num    = push_num;
                    rep_den    = push_den;
                    depth_next = depth_reg + CW'(1);
                end
            end
            KIND_POP:
            begin
                if (depth_reg == '0)
                begin
                    rep_status = STAT_UNDERFLOW;
                end
                else
                begin
                    depth_next = depth_reg - CW'(1);
                end
            end
            KIND_ARITH:
            begin
                if (depth_reg < CW'(2))
                begin
                    rep_status = STAT_UNDERFLOW;
                end
                else
                begin
                    wr_en      = 1'b1;
                    rep_valid  = 1'b1;
                    rep_rat    = res_rat;
                    rep_num    = res_num;
                    rep_den    = res_den;
                    depth_next = depth_reg - CW'(1);
                end
            end
            default:
            begin
                rep_status = STAT_OK;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            S_IDLE:
            begin
                step_next = 2'd0;
                if (req_valid)
                begin
                    if (req.kind == KIND_ARITH && depth_reg >= CW'(2))
                    begin
                        state_next = S_MUL;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_MUL:
            begin
                step_next = step_reg + 2'd1;
                if (step_reg == 2'd2)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= 2'd0;
            depth_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            if (out_load)
            begin
                depth_reg <= depth_next;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            req_reg <= req;
        end
        if (state_reg == S_MUL)
        begin
            case (step_reg)
                2'd0:    p0_reg <= prod;
                2'd1:    p1_reg <= prod;
                default: p2_reg <= prod;
            endcase
        end
        if (out_load)
        begin
            out_is_ratio_reg <= rep_valid && rep_rat;
            out_num_reg      <= rep_valid ? DATA_W'($signed(rep_num)) : '0;
            out_den_reg      <= (rep_valid && rep_rat) ? DATA_W'($signed(rep_den)) : '0;
            out_depth_reg    <= DEPTH_W'(depth_next);
            out_status_reg   <= rep_status;
        end
    end

    // stack store: one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (wr_en && out_load)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (req_fire)
        begin
            rd_a_reg <= mem[addr_a];
            rd_b_reg <= mem[addr_b];
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_is_ratio = out_is_ratio_reg;
    assign out_num      = out_num_reg;
    assign out_den      = out_den_reg;
    assign out_depth    = out_depth_reg;
    assign out_status   = out_status_reg;

endmodule

`default_nettype wire

// File: bench/rsa_stack_checker.sv
`timescale 1ns / 100ps

module rsa_stack_checker #(
    parameter int STACK_SIZE = 64
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_tvalid,
    input  wire logic                               s_tready,
    input  wire logic [rsa_pkg::TDATA_IN_W-1:0]     s_tdata,
    input  wire logic [rsa_pkg::TUSER_IN_W-1:0]     s_tuser,
    input  wire logic                               m_tvalid,
    input  wire logic                               m_tready,
    input  wire logic [rsa_pkg::TDATA_OUT_W-1:0]    m_tdata,
    input  wire logic                               m_tuser,
    output int                                      errors,
    output int                                      pending
);
    import rsa_pkg::*;

    typedef struct packed {
        logic              is_ratio;
        logic [DATA_W-1:0] num;
        logic [DATA_W-1:0] den;
        logic [DEPTH_W-1:0] depth;
        status_t           status;
    } stack_top_t;

    logic              slot_ratio [STACK_SIZE];
    logic [DATA_W-1:0] slot_num   [STACK_SIZE];
    logic [DATA_W-1:0] slot_den   [STACK_SIZE];
    int                stack_fill;

    stack_top_t expected_tops[$];
    int         fail_count;

    function automatic stack_top_t current_top(status_t st);
        stack_top_t t;
        t = '0;
        if (stack_fill > 0) begin
            t.is_ratio = slot_ratio[stack_fill-1];
            t.num      = slot_num[stack_fill-1];
            t.den      = slot_ratio[stack_fill-1] ? slot_den[stack_fill-1] : '0;
        end
        t.depth  = stack_fill[DEPTH_W-1:0];
        t.status = st;
        return t;
    endfunction

    task automatic apply_stack_op(input logic [OP_W-1:0] op, input logic ratio,
                                  input logic [DATA_W-1:0] num, input logic [DATA_W-1:0] den,
                                  output stack_top_t res);
        logic [DATA_W-1:0] an, ad, bn, bd, rn, rd;
        logic              ra, rb, rr;
        int                ia, ib;
        case (op)
            OPC_PUSH: begin
                if (stack_fill >= STACK_SIZE) begin
                    res = current_top(STAT_OVERFLOW);
                end else begin
                    slot_ratio[stack_fill] = ratio;
                    slot_num[stack_fill]   = num;
                    slot_den[stack_fill]   = ratio ? den : '0;
                    stack_fill++;
                    res = current_top(STAT_OK);
                end
            end
            OPC_POP: begin
                if (stack_fill == 0) begin
                    res = current_top(STAT_UNDERFLOW);
                end else begin
                    // report the popped entry with the reduced depth
                    res = current_top(STAT_OK);
                    stack_fill--;
                    res.depth = stack_fill[DEPTH_W-1:0];
                end
            end
            OPC_ADD, OPC_SUB, OPC_MUL, OPC_DIV: begin
                if (stack_fill < 2) begin
                    res = current_top(STAT_UNDERFLOW);
                end else begin
                    ib = stack_fill - 1;
                    ia = stack_fill - 2;
                    ra = slot_ratio[ia];
                    rb = slot_ratio[ib];
                    an = slot_num[ia];
                    bn = slot_num[ib];
                    ad = ra ? slot_den[ia] : 32'd1;
                    bd = rb ? slot_den[ib] : 32'd1;
                    rr = ra | rb;
                    // integers act as n/1; everything wraps at 32 bits
                    case (op)
                        OPC_ADD: begin
                            rn = an * bd + bn * ad;
                            rd = ad * bd;
                        end
                        OPC_SUB: begin
                            rn = an * bd - bn * ad;
                            rd = ad * bd;
                        end
                        OPC_MUL: begin
                            rn = an * bn;
                            rd = ad * bd;
                        end
                        default: begin
                            rn = an * bd;
                            rd = ad * bn;
                            rr = 1'b1;
                        end
                    endcase
                    slot_ratio[ia] = rr;
                    slot_num[ia]   = rn;
                    slot_den[ia]   = rr ? rd : '0;
                    stack_fill--;
                    res = current_top(STAT_OK);
                end
            end
            default: res = current_top(STAT_OK);
        endcase
    endtask

    task automatic check_field(input string name, input logic [DATA_W-1:0] want,
                               input logic [DATA_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin : watch
        stack_top_t want;
        stack_top_t got;
        if (!rst_n) begin
            stack_fill = 0;
            fail_count = 0;
            expected_tops.delete();
            errors  <= 0;
            pending <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                apply_stack_op(s_tuser[OP_W-1:0], s_tuser[OP_W], s_tdata[DATA_W-1:0],
                               s_tdata[2*DATA_W-1:DATA_W], want);
                expected_tops.push_back(want);
            end
            if (m_tvalid && m_tready) begin
                got.is_ratio = m_tuser;
                got.num      = m_tdata[DATA_W-1:0];
                got.den      = m_tdata[2*DATA_W-1:DATA_W];
                got.depth    = m_tdata[2*DATA_W+DEPTH_W-1:2*DATA_W];
                got.status   = status_t'(m_tdata[2*DATA_W+DEPTH_W+STATUS_W-1:2*DATA_W+DEPTH_W]);
                if (expected_tops.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h", $time, got);
                    fail_count++;
                end else begin
                    want = expected_tops.pop_front();
                    check_field("top_is_ratio", 32'(want.is_ratio), 32'(got.is_ratio));
                    check_field("top_numerator", want.num, got.num);
                    check_field("top_denominator", want.den, got.den);
                    check_field("depth", 32'(want.depth), 32'(got.depth));
                    check_field("status", 32'(want.status), 32'(got.status));
                end
            end
            errors  <= fail_count;
            pending <= expected_tops.size();
        end
    end

endmodule

// File: bench/tb_rational_stack_alu_unit.sv
`timescale 1ns / 100ps

module tb_rational_stack_alu_unit;
    import rsa_pkg::*;

    localparam logic [OP_W-1:0] OPC_SPARE_LO = 3'd6;
    localparam logic [OP_W-1:0] OPC_SPARE_HI = 3'd7;
    localparam int RANDOM_ITEMS  = 1850;
    localparam int SEGMENT_LEN   = 100;
    localparam int STALL_LIMIT   = 3000;
    localparam int HOLD_START    = 3000;
    localparam int HOLD_LEN      = 400;
    localparam int STEADY_START  = 5000;
    localparam int STEADY_LEN    = 1500;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [TDATA_IN_W-1:0]   s_axis_tdata = '0;
    logic [TUSER_IN_W-1:0]   s_axis_tuser = '0;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [TDATA_OUT_W-1:0]  m_axis_tdata;
    logic                    m_axis_tuser;

    int  errors;
    int  pending;
    int  quiet_cycles = 0;
    int  rx_cycle = 0;
    bit  no_gaps = 1'b0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    rational_stack_alu_unit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    rsa_stack_checker #(.STACK_SIZE(DEF_STACK_DEPTH)) i_checker (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_axis_tvalid),
        .s_tready (s_axis_tready),
        .s_tdata  (s_axis_tdata),
        .s_tuser  (s_axis_tuser),
        .m_tvalid (m_axis_tvalid),
        .m_tready (m_axis_tready),
        .m_tdata  (m_axis_tdata),
        .m_tuser  (m_axis_tuser),
        .errors   (errors),
        .pending  (pending)
    );

    // result side: random stalls, one long hold-off, one stretch without stalls
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            rx_cycle <= rx_cycle + 1;
            if (rx_cycle >= HOLD_START && rx_cycle < HOLD_START + HOLD_LEN)
                m_axis_tready <= 1'b0;
            else if (rx_cycle >= STEADY_START && rx_cycle < STEADY_START + STEADY_LEN)
                m_axis_tready <= 1'b1;
            else
                m_axis_tready <= ($urandom_range(0, 99) >= 8);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    task automatic send_request(input logic [OP_W-1:0] op, input logic ratio,
                                input logic [DATA_W-1:0] num, input logic [DATA_W-1:0] den);
        while (!no_gaps && $urandom_range(0, 99) < 8)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {den, num};
        s_axis_tuser  <= {ratio, op};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'h0000_0000;
            1: return 32'h0000_0001;
            2: return 32'hFFFF_FFFF;
            3: return 32'h8000_0000;
            4: return 32'h7FFF_FFFF;
            5, 6: return DATA_W'($signed($urandom_range(0, 40)) - 20);
            default: return $urandom;
        endcase
    endfunction

    task automatic run_directed();
        send_request(OPC_POP,  1'b0, 32'h0, 32'h0);              // pop of empty stack
        send_request(OPC_ADD,  1'b0, 32'h0, 32'h0);              // arithmetic on empty stack
        send_request(OPC_SPARE_LO, 1'b1, 32'h1234_5678, 32'h9ABC_DEF0);
        send_request(OPC_PUSH, 1'b0, 32'h8000_0000, 32'hFFFF_FFFF); // denominator dropped
        send_request(OPC_DIV,  1'b0, 32'h0, 32'h0);              // only one operand
        send_request(OPC_PUSH, 1'b0, 32'h7FFF_FFFF, 32'h0);
        send_request(OPC_ADD,  1'b0, 32'h0, 32'h0);              // int + int
        send_request(OPC_PUSH, 1'b1, 32'h7FFF_FFFF, 32'h8000_0000);
        send_request(OPC_MUL,  1'b0, 32'h0, 32'h0);              // int * ratio
        send_request(OPC_PUSH, 1'b0, 32'hFFFF_FFFF, 32'h5555_5555);
        send_request(OPC_SUB,  1'b0, 32'h0, 32'h0);              // ratio - int
        send_request(OPC_PUSH, 1'b1, 32'h0000_0005, 32'h0);      // zero denominator
        send_request(OPC_DIV,  1'b0, 32'h0, 32'h0);              // ratio / ratio
        send_request(OPC_PUSH, 1'b0, 32'h0, 32'h0);
        send_request(OPC_DIV,  1'b0, 32'h0, 32'h0);              // ratio / int zero
        send_request(OPC_PUSH, 1'b0, 32'h0000_0007, 32'h0);
        send_request(OPC_SPARE_HI, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(OPC_PUSH, 1'b0, 32'h0000_0003, 32'h0);
        send_request(OPC_DIV,  1'b0, 32'h0, 32'h0);              // int / int gives ratio
        send_request(OPC_PUSH, 1'b1, 32'hFFFF_FFFD, 32'hFFFF_FFF9);
        send_request(OPC_ADD,  1'b0, 32'h0, 32'h0);              // ratio + ratio
        send_request(OPC_SUB,  1'b0, 32'h0, 32'h0);
        send_request(OPC_POP,  1'b0, 32'h0, 32'h0);
        send_request(OPC_POP,  1'b0, 32'h0, 32'h0);
    endtask

    task automatic run_random();
        int             counted;
        int             issued;
        int             push_share;
        int             roll;
        logic [OP_W-1:0] op;
        counted    = 0;
        issued     = 0;
        push_share = 45;
        while (counted < RANDOM_ITEMS)
        begin
            // switch between filling, balanced and draining phases
            if (issued % SEGMENT_LEN == 0)
            begin
                case ($urandom_range(0, 2))
                    0: push_share = 78;
                    1: push_share = 45;
                    default: push_share = 20;
                endcase
            end
            no_gaps = (counted >= 700 && counted < 1000);
            roll = $urandom_range(0, 99);
            if (roll < 2)
                op = $urandom_range(0, 1) ? OPC_SPARE_HI : OPC_SPARE_LO;
            else if (roll < push_share)
                op = OPC_PUSH;
            else if (roll < push_share + 8)
                op = OPC_POP;
            else
                op = opcode_t'($urandom_range(OPC_ADD, OPC_DIV));
            send_request(op, 1'($urandom_range(0, 1)), pick_value(), pick_value());
            issued++;
            if (op != OPC_SPARE_LO && op != OPC_SPARE_HI)
                counted++;
        end
        no_gaps = 1'b0;
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        run_directed();
        run_random();
        s_axis_tvalid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
